[rtl/ptrp_pkg.sv]
// ----------------------------------------------------------------------------
// ptrp_pkg: shared types and constants
// Request payloads, saturation helpers and pipeline latencies for the
// primitive to Roe parameter transform.
// ----------------------------------------------------------------------------
package ptrp_pkg;

  localparam int FRAC_BITS = 24;
  localparam logic [63:0] Q_ONE   = 64'h0000_0000_0100_0000;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_MAG = 64'h8000_0000_0000_0000;

  // numerator bits of a quotient: 64-bit magnitude shifted up by FRAC_BITS
  localparam int DIV_BITS = 64 + FRAC_BITS;
  localparam int DIV_LAT  = DIV_BITS + 2;
  localparam int MUL_LAT  = 4;
  localparam int SQRT_DIG = 44;
  localparam int SQRT_LAT = SQRT_DIG + 1;
  localparam int PIPE_LAT = 4 * DIV_LAT + SQRT_LAT + MUL_LAT;

  localparam logic [2:0] REG_GAS_CONSTANT    = 3'd0;
  localparam logic [2:0] REG_HEAT_RATIO      = 3'd1;
  localparam logic [2:0] REG_REF_PRESSURE    = 3'd2;
  localparam logic [2:0] REG_REF_TEMPERATURE = 3'd3;
  localparam logic [2:0] REG_REF_VELOCITY    = 3'd4;
  localparam logic [2:0] REG_REF_LENGTH      = 3'd5;

  typedef struct packed {
    logic [62:0]        pressure;
    logic signed [63:0] velocity_x;
    logic signed [63:0] velocity_y;
    logic [62:0]        temperature;
    logic signed [63:0] coord_x;
    logic signed [63:0] coord_y;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [62:0]        root_density;
    logic signed [63:0] scaled_enthalpy;
    logic signed [63:0] scaled_momentum_x;
    logic signed [63:0] scaled_momentum_y;
    logic signed [63:0] scaled_x;
    logic signed [63:0] scaled_y;
    logic               math_error;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic        flt;
    logic [63:0] val;
  } sat_t;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  // sign and magnitude to a two's complement pattern, clamping at 64 bits
  function automatic sat_t sat_pack(input logic neg, input logic [127:0] mag);
    logic [63:0] lim;
    logic [63:0] v;
    logic        f;
    lim = neg ? MIN_MAG : MAX_POS;
    v   = mag[63:0];
    f   = 1'b0;
    if ((mag[127:64] != 64'd0) || (mag[63:0] > lim)) begin
      f = 1'b1;
      v = lim;
    end
    sat_pack.flt = f;
    sat_pack.val = neg ? (64'd0 - v) : v;
  endfunction

endpackage

[rtl/ptrp_dly.sv]
// ----------------------------------------------------------------------------
// ptrp_dly: payload delay line
// Shifts a side bundle along with the arithmetic units while enabled.
// ----------------------------------------------------------------------------
module ptrp_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

[rtl/ptrp_mul.sv]
// ----------------------------------------------------------------------------
// ptrp_mul: pipelined Q40.24 multiplier
// Sign-magnitude 64x64 product from 32x32 partials, truncated by 24 bits,
// saturated to 64 bits. Four stages.
// ----------------------------------------------------------------------------
module ptrp_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y,
  output logic        flt
);

  logic [63:0]  am_r, bm_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] prod_r;
  ptrp_pkg::sat_t res_r;
  logic [127:0] shifted;
  ptrp_pkg::sat_t res_nxt;

  always_comb begin
    shifted = {24'd0, prod_r[127:24]};
    res_nxt = ptrp_pkg::sat_pack(neg3_r && (shifted != 128'd0), shifted);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r   <= ptrp_pkg::mag64(a);
      bm_r   <= ptrp_pkg::mag64(b);
      neg1_r <= a[63] ^ b[63];
      p00_r  <= am_r[31:0]  * bm_r[31:0];
      p01_r  <= am_r[31:0]  * bm_r[63:32];
      p10_r  <= am_r[63:32] * bm_r[31:0];
      p11_r  <= am_r[63:32] * bm_r[63:32];
      neg2_r <= neg1_r;
      prod_r <= {p11_r, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0};
      neg3_r <= neg2_r;
      res_r  <= res_nxt;
    end
  end

  assign y   = res_r.val;
  assign flt = res_r.flt;

endmodule

[rtl/ptrp_div.sv]
// ----------------------------------------------------------------------------
// ptrp_div: pipelined Q40.24 divider
// Restoring division, one quotient bit per stage, of a*2^24 by b in
// sign-magnitude form; zero divisor saturates with the numerator's sign.
// ----------------------------------------------------------------------------
module ptrp_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y,
  output logic        flt
);

  localparam int NB = ptrp_pkg::DIV_BITS;

  logic [63:0]   am_r  [NB+1];
  logic [63:0]   bm_r  [NB+1];
  logic [63:0]   rem_r [NB+1];
  logic [NB-1:0] quo_r [NB+1];
  logic          neg_r [NB+1];
  logic          xneg_r[NB+1];
  logic          bz_r  [NB+1];
  ptrp_pkg::sat_t res_r;
  ptrp_pkg::sat_t res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      am_r[0]   <= ptrp_pkg::mag64(a);
      bm_r[0]   <= ptrp_pkg::mag64(b);
      rem_r[0]  <= 64'd0;
      quo_r[0]  <= '0;
      neg_r[0]  <= a[63] ^ b[63];
      xneg_r[0] <= a[63];
      bz_r[0]   <= (b == 64'd0);
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_stage
    localparam int K = NB - 1 - i;
    logic        nbit;
    logic [64:0] rem2;
    logic [64:0] diff;
    logic        ge;

    if (K >= ptrp_pkg::FRAC_BITS) begin : g_bit
      assign nbit = am_r[i][K-ptrp_pkg::FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      rem2 = {rem_r[i], nbit};
      diff = rem2 - {1'b0, bm_r[i]};
      ge   = (rem2 >= {1'b0, bm_r[i]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        am_r[i+1]   <= am_r[i];
        bm_r[i+1]   <= bm_r[i];
        rem_r[i+1]  <= ge ? diff[63:0] : rem2[63:0];
        quo_r[i+1]  <= {quo_r[i][NB-2:0], ge};
        neg_r[i+1]  <= neg_r[i];
        xneg_r[i+1] <= xneg_r[i];
        bz_r[i+1]   <= bz_r[i];
      end
    end
  end

  always_comb begin
    if (bz_r[NB]) begin
      res_nxt     = ptrp_pkg::sat_pack(xneg_r[NB], {64'd1, 64'd0});
      res_nxt.flt = 1'b1;
    end else begin
      res_nxt = ptrp_pkg::sat_pack(neg_r[NB] && (quo_r[NB] != '0),
                                   {{(128-NB){1'b0}}, quo_r[NB]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign y   = res_r.val;
  assign flt = res_r.flt;

endmodule

[rtl/ptrp_sqrt.sv]
// ----------------------------------------------------------------------------
// ptrp_sqrt: pipelined Q40.24 square root
// Digit-by-digit floor(sqrt(x*2^24)), one root bit per stage.
// ----------------------------------------------------------------------------
module ptrp_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] x,
  output logic [43:0] root
);

  localparam int ND = ptrp_pkg::SQRT_DIG;

  logic [62:0] x_r   [ND+1];
  logic [45:0] rem_r [ND+1];
  logic [43:0] root_r[ND+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x;
      rem_r[0]  <= 46'd0;
      root_r[0] <= 44'd0;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_digit
    logic [87:0] t;
    logic [47:0] rem2;
    logic [47:0] trial;
    logic [47:0] diff;
    logic        ge;

    always_comb begin
      t     = {1'b0, x_r[j], 24'd0};
      rem2  = {rem_r[j], t[87-2*j -: 2]};
      trial = {2'b00, root_r[j], 2'b01};
      diff  = rem2 - trial;
      ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j+1]    <= x_r[j];
        rem_r[j+1]  <= ge ? diff[45:0] : rem2[45:0];
        root_r[j+1] <= {root_r[j][42:0], ge};
      end
    end
  end

  assign root = root_r[ND];

endmodule

[rtl/primitive_to_roe_parameter_core.sv]
// ----------------------------------------------------------------------------
// primitive_to_roe_parameter_core: perfect-gas Roe vector per mesh point
// Density, reference density, root density and total enthalpy in Q40.24,
// scaled by the reference velocity; coordinates scaled by reference length.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------
//   in       | sink      | in_valid / in_stall  | in_data  (in_t)
//   out      | source    | out_valid / out_stall| out_data (out_t)
//   config   | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
// One request enters per cycle while in_stall is low; the pipeline depth PIPE_LAT
// is set by four chained bit-per-stage dividers, the 45-stage square root
// and one 4-stage multiplier.
// The whole pipeline holds while out_valid is high and out_stall is set.
// Reset clears the valid bits and loads the default configuration values.
// ----------------------------------------------------------------------------
module primitive_to_roe_parameter_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ptrp_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ptrp_pkg::out_t   out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int D = ptrp_pkg::DIV_LAT;
  localparam int M = ptrp_pkg::MUL_LAT;
  localparam int Q = ptrp_pkg::SQRT_LAT;
  localparam int L = ptrp_pkg::PIPE_LAT;

  logic [62:0] gas_r, gamma_r, pref_r, tref_r, uref_r, lref_r;
  logic [L-1:0] vld_r;
  logic en;
  logic [2:0] widx;

  // configuration registers
  assign pready = 1'b1;
  assign widx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r   <= 63'd4815060992;
      gamma_r <= 63'd23488102;
      pref_r  <= 63'd1699951411200;
      tref_r  <= 63'd4831838208;
      uref_r  <= 63'd16777216;
      lref_r  <= 63'd16777216;
    end else if (psel && penable && pwrite) begin
      case (widx)
        ptrp_pkg::REG_GAS_CONSTANT:    gas_r   <= pwdata[62:0];
        ptrp_pkg::REG_HEAT_RATIO:      gamma_r <= pwdata[62:0];
        ptrp_pkg::REG_REF_PRESSURE:    pref_r  <= pwdata[62:0];
        ptrp_pkg::REG_REF_TEMPERATURE: tref_r  <= pwdata[62:0];
        ptrp_pkg::REG_REF_VELOCITY:    uref_r  <= pwdata[62:0];
        ptrp_pkg::REG_REF_LENGTH:      lref_r  <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      ptrp_pkg::REG_GAS_CONSTANT:    prdata = {1'b0, gas_r};
      ptrp_pkg::REG_HEAT_RATIO:      prdata = {1'b0, gamma_r};
      ptrp_pkg::REG_REF_PRESSURE:    prdata = {1'b0, pref_r};
      ptrp_pkg::REG_REF_TEMPERATURE: prdata = {1'b0, tref_r};
      ptrp_pkg::REG_REF_VELOCITY:    prdata = {1'b0, uref_r};
      ptrp_pkg::REG_REF_LENGTH:      prdata = {1'b0, lref_r};
      default:                       prdata = 64'd0;
    endcase
  end

  // global advance: hold everything while a finished result waits
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[L-1];

  logic [63:0] gas64, uref64;
  assign gas64  = {1'b0, gas_r};
  assign uref64 = {1'b0, uref_r};

  // ---- group A: first quotients and squares
  logic [63:0] d1_q, d2_q, hr_q, sx_q, sy_q;
  logic        d1_f, d2_f, hr_f, sx_f, sy_f;
  logic [63:0] vx2_m, vy2_m, u2_m;
  logic        vx2_mf, vy2_mf, u2_mf;

  ptrp_div u_d1 (.clk, .en, .a({1'b0, pref_r}), .b({1'b0, tref_r}), .y(d1_q), .flt(d1_f));
  ptrp_div u_d2 (.clk, .en, .a({1'b0, in_data.pressure}), .b({1'b0, in_data.temperature}),
                 .y(d2_q), .flt(d2_f));
  ptrp_div u_dh (.clk, .en, .a({1'b0, gamma_r}), .b({1'b0, gamma_r} - ptrp_pkg::Q_ONE),
                 .y(hr_q), .flt(hr_f));
  ptrp_div u_dx (.clk, .en, .a(in_data.coord_x), .b({1'b0, lref_r}), .y(sx_q), .flt(sx_f));
  ptrp_div u_dy (.clk, .en, .a(in_data.coord_y), .b({1'b0, lref_r}), .y(sy_q), .flt(sy_f));
  ptrp_mul u_mvx (.clk, .en, .a(in_data.velocity_x), .b(in_data.velocity_x),
                  .y(vx2_m), .flt(vx2_mf));
  ptrp_mul u_mvy (.clk, .en, .a(in_data.velocity_y), .b(in_data.velocity_y),
                  .y(vy2_m), .flt(vy2_mf));
  ptrp_mul u_mu2 (.clk, .en, .a(uref64), .b(uref64), .y(u2_m), .flt(u2_mf));

  logic [63:0] vx2, vy2, u2;
  logic        vx2_f, vy2_f, u2_f;
  ptrp_dly #(.W(195), .N(D-M)) u_dly_sq (
    .clk, .en,
    .d({vx2_m, vx2_mf, vy2_m, vy2_mf, u2_m, u2_mf}),
    .q({vx2, vx2_f, vy2, vy2_f, u2, u2_f})
  );

  logic [63:0] a_vx, a_vy;
  logic [62:0] a_t;
  logic        a_last;
  ptrp_dly #(.W(192), .N(D)) u_dly_a (
    .clk, .en,
    .d({in_data.velocity_x, in_data.velocity_y, in_data.temperature, in_data.last_point}),
    .q({a_vx, a_vy, a_t, a_last})
  );

  // ---- group B: densities and enthalpy
  logic f_a;
  logic [63:0] kin_a;
  assign f_a   = d1_f | d2_f | hr_f | sx_f | sy_f | vx2_f | vy2_f | u2_f;
  assign kin_a = (vx2 + vy2) >> 1;

  logic [63:0] rref_q, rho_q;
  logic        rref_f, rho_f;
  ptrp_div u_drr (.clk, .en, .a(d1_q), .b(gas64), .y(rref_q), .flt(rref_f));
  ptrp_div u_drh (.clk, .en, .a(d2_q), .b(gas64), .y(rho_q), .flt(rho_f));

  logic [63:0] m1_y, m2_y;
  logic        m1_f, m2_f;
  logic [62:0] b_t;
  logic [63:0] b_kin1, b_kin2;
  ptrp_mul u_m1 (.clk, .en, .a(hr_q), .b(gas64), .y(m1_y), .flt(m1_f));
  ptrp_dly #(.W(127), .N(M)) u_dly_t (
    .clk, .en, .d({a_t, kin_a}), .q({b_t, b_kin1})
  );
  ptrp_mul u_m2 (.clk, .en, .a(m1_y), .b({1'b0, b_t}), .y(m2_y), .flt(m2_f));
  logic b_m1f;
  ptrp_dly #(.W(65), .N(M)) u_dly_k (
    .clk, .en, .d({b_kin1, m1_f}), .q({b_kin2, b_m1f})
  );

  logic [63:0] h_r, hsum;
  logic        hf_r, hovf;
  always_comb begin
    hsum = m2_y + b_kin2;
    hovf = (m2_y[63] == b_kin2[63]) && (hsum[63] != m2_y[63]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= hovf ? (m2_y[63] ? ptrp_pkg::MIN_MAG : ptrp_pkg::MAX_POS) : hsum;
      hf_r <= hovf | m2_f | b_m1f;
    end
  end

  logic [63:0] b_h;
  logic        b_hf;
  ptrp_dly #(.W(65), .N(D-2*M-1)) u_dly_h (
    .clk, .en, .d({h_r, hf_r}), .q({b_h, b_hf})
  );

  logic [63:0] b_vx, b_vy, b_sx, b_sy, b_u2;
  logic        b_last, b_fa;
  ptrp_dly #(.W(322), .N(D)) u_dly_b (
    .clk, .en,
    .d({a_vx, a_vy, sx_q, sy_q, u2, a_last, f_a}),
    .q({b_vx, b_vy, b_sx, b_sy, b_u2, b_last, b_fa})
  );

  // ---- group C: density ratio
  logic f_b;
  assign f_b = b_fa | rref_f | rho_f | b_hf;

  logic [63:0] rat_q;
  logic        rat_f;
  ptrp_div u_drat (.clk, .en, .a(rho_q), .b(rref_q), .y(rat_q), .flt(rat_f));

  logic [63:0] c_h, c_vx, c_vy, c_sx, c_sy, c_u2;
  logic        c_last, c_fb;
  ptrp_dly #(.W(386), .N(D)) u_dly_c (
    .clk, .en,
    .d({b_h, b_vx, b_vy, b_sx, b_sy, b_u2, b_last, f_b}),
    .q({c_h, c_vx, c_vy, c_sx, c_sy, c_u2, c_last, c_fb})
  );

  // ---- group D: root density
  logic f_c;
  assign f_c = c_fb | rat_f;

  logic [43:0] root;
  ptrp_sqrt u_sqrt (.clk, .en, .x(rat_q[62:0]), .root(root));

  logic [63:0] e_h, e_vx, e_vy, e_sx, e_sy, e_u2;
  logic        e_last, e_fc;
  ptrp_dly #(.W(386), .N(Q)) u_dly_d (
    .clk, .en,
    .d({c_h, c_vx, c_vy, c_sx, c_sy, c_u2, c_last, f_c}),
    .q({e_h, e_vx, e_vy, e_sx, e_sy, e_u2, e_last, e_fc})
  );

  // ---- group E: root-weighted products
  logic [63:0] root64;
  assign root64 = {20'd0, root};

  logic [63:0] rh_y, rvx_y, rvy_y;
  logic        rh_f, rvx_f, rvy_f;
  ptrp_mul u_mrh (.clk, .en, .a(root64), .b(e_h),  .y(rh_y),  .flt(rh_f));
  ptrp_mul u_mrx (.clk, .en, .a(root64), .b(e_vx), .y(rvx_y), .flt(rvx_f));
  ptrp_mul u_mry (.clk, .en, .a(root64), .b(e_vy), .y(rvy_y), .flt(rvy_f));

  logic [43:0] f_root;
  logic [63:0] f_sx, f_sy, f_u2;
  logic        f_last, f_fc;
  ptrp_dly #(.W(238), .N(M)) u_dly_e (
    .clk, .en,
    .d({root, e_sx, e_sy, e_u2, e_last, e_fc}),
    .q({f_root, f_sx, f_sy, f_u2, f_last, f_fc})
  );

  // ---- group F: reference velocity scaling
  logic f_e;
  assign f_e = f_fc | rh_f | rvx_f | rvy_f;

  logic [63:0] se_q, smx_q, smy_q;
  logic        se_f, smx_f, smy_f;
  ptrp_div u_dse (.clk, .en, .a(rh_y),  .b(f_u2),   .y(se_q),  .flt(se_f));
  ptrp_div u_dmx (.clk, .en, .a(rvx_y), .b(uref64), .y(smx_q), .flt(smx_f));
  ptrp_div u_dmy (.clk, .en, .a(rvy_y), .b(uref64), .y(smy_q), .flt(smy_f));

  logic [43:0] o_root;
  logic [63:0] o_sx, o_sy;
  logic        o_last, o_fe;
  ptrp_dly #(.W(174), .N(D)) u_dly_f (
    .clk, .en,
    .d({f_root, f_sx, f_sy, f_last, f_e}),
    .q({o_root, o_sx, o_sy, o_last, o_fe})
  );

  always_comb begin
    out_data.root_density      = {19'd0, o_root};
    out_data.scaled_enthalpy   = se_q;
    out_data.scaled_momentum_x = smx_q;
    out_data.scaled_momentum_y = smy_q;
    out_data.scaled_x          = o_sx;
    out_data.scaled_y          = o_sy;
    out_data.math_error        = o_fe | se_f | smx_f | smy_f;
    out_data.last_out          = o_last;
  end

endmodule
